// ----- hdl/assert_macros.svh -----
// Assertion macros used by the converter top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/ffpc_pkg.sv -----
// Shared types and constants for the float/fixed converter.
// No dependencies.
`timescale 1ns / 1ps
package ffpc_pkg;
    typedef enum logic [1:0] {
        FN_INT2FIX = 2'd0,
        FN_FLT2FIX = 2'd1,
        FN_FIX2FLT = 2'd2,
        FN_FIX2INT = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand;
    } t_in_word;

    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } t_out_word;

    // Classified item passed from front to back.
    typedef struct packed {
        t_func       func;
        logic        sign;
        logic        nan;
        logic        over;     // float overflow already known
        logic        zero;     // magnitude result known zero
        logic [31:0] value;    // operand or magnitude source
        logic [5:0]  lz;       // leading-zero count of fixed magnitude
        logic signed [9:0] sh; // float to fixed shift amount
    } t_job;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
endpackage

// ----- hdl/ffpc_front.sv -----
// Front end: accepts words, decodes float fields, counts leading zeros.
// Depends on ffpc_pkg.
`timescale 1ns / 1ps
module ffpc_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ffpc_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output ffpc_pkg::t_job    o_job
);
    logic           r_valid, n_valid;
    ffpc_pkg::t_job r_job, n_job;
    logic [31:0]    mag;
    logic [7:0]     expo;
    logic [22:0]    frac;
    logic [23:0]    mant;

    assign o_stall = r_valid && i_stall;

    // Classify the incoming word.
    always_comb begin
        n_job = '0;
        n_job.func = ffpc_pkg::t_func'(i_data.func);
        n_job.sign = i_data.operand[31];
        expo = i_data.operand[30:23];
        frac = i_data.operand[22:0];
        mant = {(expo != 8'd0), frac};
        mag = i_data.operand[31] ? (32'd0 - i_data.operand) : i_data.operand;
        n_job.value = i_data.operand;
        n_job.lz = 6'd32;
        for (int k = 0; k < 32; k++) begin
            if (mag[k]) n_job.lz = 6'(31 - k);
        end
        if (n_job.func == ffpc_pkg::FN_FLT2FIX) begin
            n_job.value = {8'd0, mant};
            n_job.sh = 10'(expo == 8'd0 ? 1 : expo) - 10'sd150 + 10'(FRACTION_BITS);
            n_job.nan = (expo == 8'hFF) && (frac != 23'd0);
            n_job.over = (expo == 8'hFF) || (mant != 24'd0 && n_job.sh > 10'sd40);
            n_job.zero = (mant == 24'd0) || (n_job.sh < -10'sd25);
        end else if (n_job.func == ffpc_pkg::FN_FIX2FLT) begin
            n_job.value = mag;
            n_job.zero = (i_data.operand == 32'd0);
        end
    end

    assign n_valid = o_stall ? r_valid : i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
        if (!o_stall) r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

// ----- hdl/ffpc_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on ffpc_pkg.
`timescale 1ns / 1ps
module ffpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ffpc_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output ffpc_pkg::t_job o_job
);
    ffpc_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

// ----- hdl/ffpc_back.sv -----
// Back end: shift, round, pack, and output register.
// Depends on ffpc_pkg.
`timescale 1ns / 1ps
module ffpc_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ffpc_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_stall,
    output ffpc_pkg::t_out_word o_data
);
    logic                r_valid;
    ffpc_pkg::t_out_word r_data, n_data;
    logic [63:0] wide;
    logic [32:0] fmag;
    logic [31:0] rem_mask, rem, half;
    logic [5:0]  n;
    logic [4:0]  p;
    logic [31:0] nm, frem, fhalf;
    logic [24:0] fmant;
    logic [7:0]  fexp;
    logic        over;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        n_data = '0;
        wide = '0; fmag = '0; rem_mask = '0; rem = '0; half = '0; n = '0;
        p = '0; nm = '0; frem = '0; fhalf = '0; fmant = '0; fexp = '0; over = 1'b0;
        unique case (i_job.func)
            ffpc_pkg::FN_INT2FIX: n_data.result = i_job.value << FRACTION_BITS;
            ffpc_pkg::FN_FIX2INT: n_data.result = 32'($signed(i_job.value) >>> FRACTION_BITS);
            ffpc_pkg::FN_FLT2FIX: begin
                if (i_job.sh >= 0) begin
                    wide = {40'd0, i_job.value[23:0]} << i_job.sh[5:0];
                    fmag = (wide[63:33] != 0) ? {1'b1, 32'd0} : wide[32:0];
                end else begin
                    n = 6'(-i_job.sh);
                    rem_mask = (32'd1 << n) - 32'd1;
                    rem = i_job.value & rem_mask;
                    half = 32'd1 << (n - 6'd1);
                    fmag = 33'(i_job.value >> n) + 33'(rem >= half);
                end
                if (i_job.zero) fmag = '0;
                over = i_job.over || (!i_job.sign && fmag > 33'h7FFF_FFFF)
                       || (i_job.sign && fmag > 33'h8000_0000);
                if (i_job.nan) begin
                    n_data.result = '0;
                    n_data.saturated = 1'b1;
                end else if (over) begin
                    n_data.result = i_job.sign ? ffpc_pkg::SAT_NEG : ffpc_pkg::SAT_POS;
                    n_data.saturated = 1'b1;
                end else begin
                    n_data.result = i_job.sign ? (32'd0 - fmag[31:0]) : fmag[31:0];
                end
            end
            ffpc_pkg::FN_FIX2FLT: begin
                p = 5'(6'd31 - i_job.lz);
                nm = i_job.value << i_job.lz;       // leading one at bit 31
                frem = {nm[7:0], 24'd0};
                fhalf = 32'h8000_0000;
                fmant = {1'b0, nm[31:8]};
                if (frem > fhalf || (frem == fhalf && fmant[0])) fmant = fmant + 25'd1;
                fexp = 8'(p) - 8'(FRACTION_BITS) + 8'd127;
                if (fmant[24]) begin
                    fmant = fmant >> 1;
                    fexp = fexp + 8'd1;
                end
                if (!i_job.zero)
                    n_data.result = {i_job.sign, fexp, fmant[22:0]};
            end
            default: n_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)       r_valid <= 1'b0;
        else if (!o_stall)  r_valid <= i_valid;
        if (!o_stall) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- hdl/float_fixed_point_converter_core.sv -----
// Top level of the float/fixed converter: front, queue, back.
// Depends on ffpc_pkg, ffpc_front, ffpc_queue, ffpc_back, assert_macros.svh.
//   channel | direction | handshake          | payload
//   in      | input     | i_valid / o_stall  | i_data (t_in_word)
//   out     | output    | o_valid / i_stall  | o_data (t_out_word)
// One word per cycle unless stalled; passes front register, queue, output register.
// Synchronous active-low reset empties all stages; payload registers are not reset.
// Output stall backs up through the two-entry queue to the front register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float_fixed_point_converter_core #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ffpc_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ffpc_pkg::t_out_word o_data
);
    logic           f_valid, f_stall, b_valid, b_stall;
    ffpc_pkg::t_job f_job, b_job;

    ffpc_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid(f_valid), .i_stall(f_stall), .o_job(f_job)
    );

    ffpc_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_job(f_job),
        .o_valid(b_valid), .i_stall(b_stall), .o_job(b_job)
    );

    ffpc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_stall(b_stall), .i_job(b_job),
        .o_valid, .i_stall, .o_data
    );

    `ASSERT_IMPLIES(a_no_stall_idle, i_clk, i_rst_n, !o_valid, !b_stall, "back stalls while empty")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "output word dropped")
    `ASSERT_IMPLIES(a_sat_func, i_clk, i_rst_n, o_valid && o_data.saturated, o_data.result == 32'd0 || o_data.result == ffpc_pkg::SAT_POS || o_data.result == ffpc_pkg::SAT_NEG, "bad saturated value")
endmodule

// ----- test/float_fixed_point_converter_core_checker.sv -----
// Checker for the float/fixed converter: watches both channels, predicts each
// result word and compares it. Depends on ffpc_pkg.
`timescale 1ns / 1ps
module float_fixed_point_converter_core_checker #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  ffpc_pkg::t_in_word  i_data,
    input  logic                i_valid_out,
    input  logic                i_stall,
    input  ffpc_pkg::t_out_word i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output logic                o_accepted
);
    ffpc_pkg::t_out_word pending_words[$];

    // Int to fixed: wrapping left shift.
    function automatic logic [31:0] scale_up(logic [31:0] v);
        return v << FRACTION_BITS;
    endfunction

    // Fixed to int: arithmetic right shift.
    function automatic logic [31:0] scale_down(logic [31:0] v);
        return $unsigned($signed(v) >>> FRACTION_BITS);
    endfunction

    // Fixed to IEEE single, round to nearest even.
    function automatic logic [31:0] fixed_to_single(logic [31:0] v);
        logic        sgn;
        logic [63:0] mag;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [7:0]  expo;
        int          msb;
        int          s;
        sgn = v[31];
        mag = sgn ? {32'd0, -v} : {32'd0, v};
        if (mag == 0) return 32'd0;
        msb = 31;
        while (msb > 0 && !mag[msb]) msb--;
        expo = 8'(msb - FRACTION_BITS + 127);
        if (msb <= 23) begin
            mant = mag << (23 - msb);
        end else begin
            s = msb - 23;
            rem = mag & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            mant = mag >> s;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
                mant >>= 1;
                expo++;
            end
        end
        return {sgn, expo, mant[22:0]};
    endfunction

    // IEEE single to fixed, round half away from zero, saturating.
    function automatic ffpc_pkg::t_out_word single_to_fixed(logic [31:0] v);
        ffpc_pkg::t_out_word w;
        logic        sgn;
        logic [7:0]  e;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] rem;
        logic        over;
        int          sh;
        int          n;
        sgn = v[31];
        e = v[30:23];
        m = {41'd0, v[22:0]};
        mag = 0;
        over = 1'b0;
        w = '0;
        if (e == 8'hFF) begin
            if (m != 0) begin
                w.saturated = 1'b1;
                return w;
            end
            over = 1'b1;
        end else begin
            if (e == 0) e = 8'd1;
            else m[23] = 1'b1;
            sh = int'(e) - 150 + FRACTION_BITS;
            if (m == 0) begin
                mag = 0;
            end else if (sh >= 0) begin
                if (sh > 40) over = 1'b1;
                else mag = m << sh;
            end else begin
                n = -sh;
                if (n <= 25) begin
                    rem = m & ((64'd1 << n) - 1);
                    mag = m >> n;
                    if (rem >= (64'd1 << (n - 1))) mag++;
                end
            end
            if (!sgn && mag > 64'h7FFF_FFFF) over = 1'b1;
            if (sgn && mag > 64'h8000_0000) over = 1'b1;
        end
        if (over) begin
            w.saturated = 1'b1;
            w.result = sgn ? ffpc_pkg::SAT_NEG : ffpc_pkg::SAT_POS;
        end else begin
            w.result = sgn ? -mag[31:0] : mag[31:0];
        end
        return w;
    endfunction

    function automatic ffpc_pkg::t_out_word convert_word(ffpc_pkg::t_in_word x);
        ffpc_pkg::t_out_word w;
        w = '0;
        case (ffpc_pkg::t_func'(x.func))
            ffpc_pkg::FN_INT2FIX: w.result = scale_up(x.operand);
            ffpc_pkg::FN_FLT2FIX: w = single_to_fixed(x.operand);
            ffpc_pkg::FN_FIX2FLT: w.result = fixed_to_single(x.operand);
            default:              w.result = scale_down(x.operand);
        endcase
        return w;
    endfunction

    assign o_pending = pending_words.size();
    assign o_accepted = i_rst_n && ((i_valid && !i_stall_in) || (i_valid_out && !i_stall));

    // Queue expectations on input accepts, compare on output accepts.
    always @(posedge i_clk) begin
        ffpc_pkg::t_out_word want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall_in) pending_words.push_back(convert_word(i_data));
            if (i_valid_out && !i_stall) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word: result %h saturated %b",
                           i_result.result, i_result.saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_words.pop_front();
                    if (want.result !== i_result.result) begin
                        $error("result: expected %h, got %h", want.result, i_result.result);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.saturated !== i_result.saturated) begin
                        $error("saturated: expected %b, got %b",
                               want.saturated, i_result.saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/float_fixed_point_converter_core_tb.sv -----
// Testbench top for the float/fixed converter: stimulus, idling and verdict.
// Depends on ffpc_pkg, the converter core and its checker.
`timescale 1ns / 1ps
module float_fixed_point_converter_core_tb;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    ffpc_pkg::t_in_word  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    ffpc_pkg::t_out_word o_data;
    int                  fail_count;
    int                  pending;
    logic                accepted;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    float_fixed_point_converter_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    float_fixed_point_converter_core_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_data(i_data), .i_valid_out(o_valid), .i_stall(i_stall), .i_result(o_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_accepted(accepted)
    );

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if (accepted) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[float_fixed_point_converter_core] ERROR");
            $finish;
        end
    end

    // Drive one word and hold it until accepted; random gaps before it.
    // Valid stays high after the accept so the next word can follow directly.
    task automatic send_word(ffpc_pkg::t_func fn, logic [31:0] opnd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data <= '{func: fn, operand: opnd};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random operand biased toward interesting float and fixed patterns.
    function automatic logic [31:0] pick_operand(ffpc_pkg::t_func fn);
        logic [31:0] v;
        v = $urandom();
        if (fn == ffpc_pkg::FN_FLT2FIX && $urandom_range(3) != 0) begin
            // exponent near the fixed range, including overflow and tiny values
            v[30:23] = 8'($urandom_range(100, 165));
            if ($urandom_range(7) == 0) v[22:0] = {1'($urandom_range(1)), 22'd0};
        end else if ($urandom_range(7) == 0) begin
            v = $urandom_range(1) ? 32'(int'($urandom_range(600)) - 300) : v;
        end
        return v;
    endfunction

    task automatic random_phase(int count);
        ffpc_pkg::t_func fn;
        repeat (count) begin
            fn = ffpc_pkg::t_func'($urandom_range(3));
            send_word(fn, pick_operand(fn));
        end
    endtask

    initial begin
        ffpc_pkg::t_func fn;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes and the named special cases
        for (int f = 0; f < 4; f++) begin
            fn = ffpc_pkg::t_func'(f);
            send_word(fn, 32'h0000_0000);
            send_word(fn, 32'hFFFF_FFFF);
            send_word(fn, 32'h8000_0000);
            send_word(fn, 32'h7FFF_FFFF);
        end
        send_word(ffpc_pkg::FN_FLT2FIX, 32'h7FC0_0001);   // NaN
        send_word(ffpc_pkg::FN_FLT2FIX, 32'h7F80_0000);   // +inf
        send_word(ffpc_pkg::FN_FLT2FIX, 32'hFF80_0000);   // -inf
        send_word(ffpc_pkg::FN_FLT2FIX, 32'hCB00_0000);   // -2^23, exactly the Q24.8 minimum
        send_word(ffpc_pkg::FN_FLT2FIX, 32'h4B00_0000);   // +2^23, overflows
        send_word(ffpc_pkg::FN_FLT2FIX, 32'h3B00_0000);   // tie, 2^-9
        send_word(ffpc_pkg::FN_FLT2FIX, 32'hBB00_0000);   // negative tie
        send_word(ffpc_pkg::FN_FLT2FIX, 32'h0000_0001);   // subnormal
        send_word(ffpc_pkg::FN_FIX2FLT, 32'h0100_0001);   // rounding past 24 bits

        send_idle_pct = 7;
        recv_idle_pct = 75;
        random_phase(170);
        // hold off until every expected word has come back
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        send_idle_pct = 75;
        recv_idle_pct = 7;
        random_phase(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(160);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[float_fixed_point_converter_core] OK");
        end else begin
            $display("[float_fixed_point_converter_core] ERROR");
        end
        $finish;
    end
endmodule

// ----- float_fixed_point_converter_core.f -----
+incdir+hdl
hdl/ffpc_pkg.sv
hdl/ffpc_front.sv
hdl/ffpc_queue.sv
hdl/ffpc_back.sv
hdl/float_fixed_point_converter_core.sv
test/float_fixed_point_converter_core_checker.sv
test/float_fixed_point_converter_core_tb.sv
